// ----- hw/rtl/bbc_pkg.sv -----
// Shared widths, codes and the tag entry layout of the block buffer cache.
package bbc_pkg;

   localparam int OP_W     = 3;
   localparam int DEV_W    = 8;
   localparam int BLK_W    = 32;
   localparam int EIDX_W   = 5;
   localparam int TICK_W   = 32;
   localparam int COUNT_W  = 8;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_GET     = 3'd0;
   localparam logic [OP_W-1:0] OP_MARK    = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
   localparam logic [OP_W-1:0] OP_PIN     = 3'd3;
   localparam logic [OP_W-1:0] OP_UNPIN   = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_FREE   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [DEV_W-1:0]   tag_device;
      logic [BLK_W-1:0]   tag_block;
      logic               tag_assigned;
      logic               contents_valid;
      logic [COUNT_W-1:0] reference_count;
      logic [TICK_W-1:0]  last_use_time;
   } entry_type;

endpackage

// ----- hw/rtl/bbc_req_if.sv -----
// Request channel of the block buffer cache: one operation word per handshake.
interface bbc_req_if;
   import bbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [DEV_W-1:0]  device_id;
   logic [BLK_W-1:0]  block_number;
   logic [EIDX_W-1:0] entry_index;
   logic [TICK_W-1:0] now_tick;

   modport source (
      output valid, operation, device_id, block_number, entry_index, now_tick,
      input  ready
   );

   modport sink (
      input  valid, operation, device_id, block_number, entry_index, now_tick,
      output ready
   );

endinterface

// ----- hw/rtl/bbc_rsp_if.sv -----
// Response channel of the block buffer cache: one result word per handshake.
interface bbc_rsp_if;
   import bbc_pkg::*;

   logic                valid;
   logic                ready;
   logic [EIDX_W-1:0]   result_index;
   logic                was_hit;
   logic                data_valid;
   logic [COUNT_W-1:0]  ref_count_now;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, result_index, was_hit, data_valid, ref_count_now, status,
      input  ready
   );

   modport sink (
      input  valid, result_index, was_hit, data_valid, ref_count_now, status,
      output ready
   );

endinterface

// ----- hw/rtl/block_buffer_cache_lru.sv -----
// A get passes the scan, drain and update states, every other operation the fetch and update states.
// Update waits while an earlier response is unaccepted, then registers the response, and the block is
// ready for a new request word in that same cycle. The tag memory has one read port, so a get scans
// the entries one per cycle for a match and for the oldest unreferenced entry. Reset is synchronous:
// it clears the sequencer, the response register and the per-entry written bits; an unwritten entry reads as zero.
module block_buffer_cache_lru #(
   parameter int BUFFERS = 32
) (
   input logic       clock,
   input logic       reset,
   bbc_req_if.sink   req_ch,
   bbc_rsp_if.source rsp_ch
);
   import bbc_pkg::*;

   localparam int IDX_W = $clog2(BUFFERS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFERS - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [DEV_W-1:0]  dev_ff, dev_in;
   logic [BLK_W-1:0]  blk_ff, blk_in;
   logic [EIDX_W-1:0] eidx_ff, eidx_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              in_range_ff, in_range_in;

   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              eval_ff, eval_in;
   logic [IDX_W-1:0]  eval_idx_ff, eval_idx_in;

   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   entry_type         hit_entry_ff, hit_entry_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic [TICK_W-1:0] best_ff, best_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [EIDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_dv_ff, rsp_dv_in;
   logic [COUNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;

   entry_type          mem_ff [BUFFERS];
   entry_type          rd_data_ff;
   logic               rd_init_ff;
   logic [BUFFERS-1:0] init_ff, init_in;
   entry_type          rd_entry;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic               accept;

   assign accept   = req_ch.valid && req_ch.ready;
   assign rd_addr  = (state_ff == ST_SCAN) ? scan_ff : idx_ff;
   assign rd_entry = rd_init_ff ? rd_data_ff : '0;

   always_comb begin
      entry_type           upd;
      logic [STATUS_W-1:0] st;

      state_in     = state_ff;
      op_in        = op_ff;
      dev_in       = dev_ff;
      blk_in       = blk_ff;
      eidx_in      = eidx_ff;
      tick_in      = tick_ff;
      idx_in       = idx_ff;
      in_range_in  = in_range_ff;
      scan_in      = scan_ff;
      eval_in      = eval_ff;
      eval_idx_in  = eval_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_entry_in = hit_entry_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_dv_in    = rsp_dv_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;
      init_in      = init_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      upd          = rd_entry;
      st           = STAT_OK;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_ch.operation;
               dev_in      = req_ch.device_id;
               blk_in      = req_ch.block_number;
               eidx_in     = req_ch.entry_index;
               tick_in     = req_ch.now_tick;
               idx_in      = IDX_W'(req_ch.entry_index);
               in_range_in = 32'(req_ch.entry_index) < BUFFERS;
               scan_in     = '0;
               eval_in     = 1'b0;
               hit_in      = 1'b0;
               found_in    = 1'b0;
               state_in    = (req_ch.operation == OP_GET) ? ST_SCAN : ST_FETCH;
            end
         end
         ST_SCAN: begin
            eval_in     = 1'b1;
            eval_idx_in = scan_ff;
            if (scan_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            eval_in  = 1'b0;
            state_in = ST_UPDATE;
         end
         ST_FETCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (op_ff == OP_GET) begin
                  if (hit_ff) begin
                     upd = hit_entry_ff;
                     if (upd.reference_count == COUNT_MAX) begin
                        st = STAT_OVERFLOW;
                     end else begin
                        upd.reference_count = upd.reference_count + 1'b1;
                     end
                     wr_en      = 1'b1;
                     wr_addr    = hit_idx_ff;
                     rsp_idx_in = EIDX_W'(hit_idx_ff);
                     rsp_hit_in = 1'b1;
                     rsp_dv_in  = upd.contents_valid;
                     rsp_cnt_in = upd.reference_count;
                     rsp_st_in  = st;
                  end else if (found_ff) begin
                     upd = '{tag_device: dev_ff, tag_block: blk_ff, tag_assigned: 1'b1,
                             contents_valid: 1'b0, reference_count: COUNT_W'(1),
                             last_use_time: best_ff};
                     wr_en      = 1'b1;
                     wr_addr    = pick_ff;
                     rsp_idx_in = EIDX_W'(pick_ff);
                     rsp_hit_in = 1'b0;
                     rsp_dv_in  = 1'b0;
                     rsp_cnt_in = COUNT_W'(1);
                     rsp_st_in  = STAT_OK;
                  end else begin
                     rsp_idx_in = '0;
                     rsp_hit_in = 1'b0;
                     rsp_dv_in  = 1'b0;
                     rsp_cnt_in = '0;
                     rsp_st_in  = STAT_NO_FREE;
                  end
               end else if (op_ff > OP_UNPIN) begin
                  rsp_idx_in = '0;
                  rsp_hit_in = 1'b0;
                  rsp_dv_in  = 1'b0;
                  rsp_cnt_in = '0;
                  rsp_st_in  = STAT_OK;
               end else if (!in_range_ff) begin
                  rsp_idx_in = eidx_ff;
                  rsp_hit_in = 1'b0;
                  rsp_dv_in  = 1'b0;
                  rsp_cnt_in = '0;
                  rsp_st_in  = STAT_OK;
               end else begin
                  case (op_ff)
                     OP_MARK: begin
                        upd.contents_valid = 1'b1;
                     end
                     OP_PIN: begin
                        if (upd.reference_count == COUNT_MAX) begin
                           st = STAT_OVERFLOW;
                        end else begin
                           upd.reference_count = upd.reference_count + 1'b1;
                        end
                     end
                     default: begin
                        if (op_ff == OP_RELEASE) begin
                           upd.last_use_time = tick_ff;
                        end
                        if (upd.reference_count == '0) begin
                           st = STAT_UNDERFLOW;
                        end else begin
                           upd.reference_count = upd.reference_count - 1'b1;
                        end
                     end
                  endcase
                  wr_en      = 1'b1;
                  wr_addr    = idx_ff;
                  rsp_idx_in = eidx_ff;
                  rsp_hit_in = 1'b0;
                  rsp_dv_in  = upd.contents_valid;
                  rsp_cnt_in = upd.reference_count;
                  rsp_st_in  = st;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (eval_ff) begin
         if (!hit_ff && rd_entry.tag_assigned && rd_entry.tag_device == dev_ff
             && rd_entry.tag_block == blk_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = eval_idx_ff;
            hit_entry_in = rd_entry;
         end
         if (rd_entry.reference_count == '0
             && (!found_ff || rd_entry.last_use_time < best_ff)) begin
            found_in = 1'b1;
            best_in  = rd_entry.last_use_time;
            pick_in  = eval_idx_ff;
         end
      end

      wr_data = upd;
      if (wr_en) begin
         init_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
      rd_init_ff <= init_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         eval_ff      <= 1'b0;
         init_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         eval_ff      <= eval_in;
         init_ff      <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      dev_ff       <= dev_in;
      blk_ff       <= blk_in;
      eidx_ff      <= eidx_in;
      tick_ff      <= tick_in;
      idx_ff       <= idx_in;
      in_range_ff  <= in_range_in;
      scan_ff      <= scan_in;
      eval_idx_ff  <= eval_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      found_ff     <= found_in;
      pick_ff      <= pick_in;
      best_ff      <= best_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_dv_ff    <= rsp_dv_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_st_ff    <= rsp_st_in;
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.result_index  = rsp_idx_ff;
   assign rsp_ch.was_hit       = rsp_hit_ff;
   assign rsp_ch.data_valid    = rsp_dv_ff;
   assign rsp_ch.ref_count_now = rsp_cnt_ff;
   assign rsp_ch.status        = rsp_st_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while an earlier word is still in progress");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside the update step");

   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.was_hit) |->
      (rsp_ch.status == STAT_OK || rsp_ch.status == STAT_OVERFLOW))
      else $error("hit reported with a status that a hit cannot give");

   a_write_in_update: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_UPDATE && (!$past(rsp_valid_ff) || rsp_valid_in)))
      else $error("tag memory written outside the update step");

   a_written_bits_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((init_ff & $past(init_ff)) == $past(init_ff)))
      else $error("an entry lost its written bit without a reset");
`endif

endmodule
